// ===== hw/rtl/ooksfd_pkg.sv =====
// Shared types and constants of the OOK sensor frame decoder.
package ooksfd_pkg;

  localparam int unsigned FRAME_BITS = 72;
  localparam int unsigned CNT_W      = $clog2(FRAME_BITS + 1);
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ID_W       = 7;
  localparam int unsigned ID_LSB     = 12;
  localparam int unsigned NIB_CNT    = WORD_W / 4;

  localparam logic [3:0] NIB_MASK_ALL = 4'hF;
  localparam logic [3:0] NIB_MASK_Y   = 4'h5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd2;

  localparam logic [TIME_W-1:0] SHORT_TIME_RST = 16'd1940;
  localparam logic [TIME_W-1:0] LONG_TIME_RST  = 16'd3880;
  localparam logic [TIME_W-1:0] TOLERANCE_RST  = 16'd500;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMING  = 3'd1,
    ST_SHORT   = 3'd2,
    ST_INV_ERR = 3'd3,
    ST_CSUM    = 3'd4
  } status_e;

  // Classification of one pulse pair
  typedef struct packed {
    logic abort;
    logic bit_val;
  } cls_t;

  // Outcome of the checks on a completed frame
  typedef struct packed {
    status_e            status;
    logic [WORD_W-1:0]  word;
  } chk_t;

endpackage

// ===== hw/rtl/ooksfd_classify.sv =====
// Pulse pair timing classifier: turns a high/low pair into a bit or an abort.
module ooksfd_classify (
  input  logic [ooksfd_pkg::TIME_W-1:0] short_time_i,
  input  logic [ooksfd_pkg::TIME_W-1:0] long_time_i,
  input  logic [ooksfd_pkg::TIME_W-1:0] tolerance_i,
  input  logic [ooksfd_pkg::TIME_W-1:0] high_time_i,
  input  logic [ooksfd_pkg::TIME_W-1:0] low_time_i,
  output ooksfd_pkg::cls_t              cls_o
);
  import ooksfd_pkg::*;

  logic [TIME_W-1:0] hi_diff;
  logic [TIME_W-1:0] lo_short_diff;
  logic [TIME_W-1:0] lo_long_diff;
  logic [TIME_W:0]   tol_x2;
  logic [TIME_W+1:0] long_x3;
  logic              hi_bad;
  logic              lo_short;
  logic              lo_long;
  logic              lo_sync;

  always_comb begin
    hi_diff       = (high_time_i > short_time_i) ? high_time_i - short_time_i
                                                 : short_time_i - high_time_i;
    lo_short_diff = (low_time_i > short_time_i) ? low_time_i - short_time_i
                                                : short_time_i - low_time_i;
    lo_long_diff  = (low_time_i > long_time_i) ? low_time_i - long_time_i
                                               : long_time_i - low_time_i;
    tol_x2  = {tolerance_i, 1'b0};
    long_x3 = {2'b00, long_time_i} + {1'b0, long_time_i, 1'b0};

    hi_bad   = {1'b0, hi_diff} >= tol_x2;
    lo_short = lo_short_diff < tolerance_i;
    lo_long  = lo_long_diff < tolerance_i;
    lo_sync  = {2'b00, low_time_i} > long_x3;

    cls_o.abort   = hi_bad || !(lo_short || lo_long || lo_sync);
    // short gap wins over long gap when the windows overlap
    cls_o.bit_val = !lo_short && lo_long;
  end

endmodule

// ===== hw/rtl/ooksfd_check.sv =====
// Frame checks: inverted copy compare and nibble checksum on a full frame.
module ooksfd_check (
  input  logic [ooksfd_pkg::FRAME_BITS-1:0] frame_i,
  output ooksfd_pkg::chk_t                  chk_o
);
  import ooksfd_pkg::*;

  logic [WORD_W-1:0] word1;
  logic [WORD_W-1:0] word2;
  logic [7:0]        check;
  logic [6:0]        sum_x;
  logic [6:0]        sum_y;
  logic [7:0]        calc;

  always_comb begin
    word1 = frame_i[FRAME_BITS-1 -: WORD_W];
    word2 = frame_i[FRAME_BITS-1-WORD_W -: WORD_W];
    check = frame_i[7:0];
    sum_x = '0;
    sum_y = '0;
    for (int i = 0; i < NIB_CNT; i++) begin
      sum_x = sum_x + {3'b000, word1[4*i +: 4] & NIB_MASK_ALL};
      sum_y = sum_y + {3'b000, word1[4*i +: 4] & NIB_MASK_Y};
    end
    calc = {~sum_x[3:0], ~sum_y[3:0]};

    chk_o.word = word1;
    if (word1 != ~word2) begin
      chk_o.status = ST_INV_ERR;
    end else if (calc != check) begin
      chk_o.status = ST_CSUM;
    end else begin
      chk_o.status = ST_OK;
    end
  end

endmodule

// ===== hw/rtl/ook_sensor_frame_decoder.sv =====
// Top level of the OOK pulse-distance sensor frame decoder.
//
// Input channel: one pulse pair per transfer (start_req, high_time, low_time,
// last_pair) under in_valid_i / in_stall_o. Output channel: one result per
// finished capture (status, data_word, sensor_id) under out_valid_o /
// out_stall_i. Configuration: cfg_we_i writes cfg_data_i into the register at
// cfg_idx_i (0 short time, 1 long time, 2 tolerance); write only while idle.
//
// A pair is registered on transfer into the input register, then classified,
// shifted into the frame and checked, with the result landing in the output
// register. One pair per cycle is sustained while the receiver does not
// stall. The frame state feeds back within the single compute stage, so
// consecutive pairs see each other's effect without bubbles.
//
// Reset loads the default timings, clears the frame and count, and leaves
// the decoder idle: pairs are dropped until one arrives with start_req set.
// While the receiver stalls a waiting result, the compute stage holds and
// in_stall_o rises once the input register is occupied as well.
module ook_sensor_frame_decoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               start_req_i,
  input  logic [ooksfd_pkg::TIME_W-1:0]      high_time_i,
  input  logic [ooksfd_pkg::TIME_W-1:0]      low_time_i,
  input  logic                               last_pair_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         status_o,
  output logic [ooksfd_pkg::WORD_W-1:0]      data_word_o,
  output logic [ooksfd_pkg::ID_W-1:0]        sensor_id_o,
  input  logic                               cfg_we_i,
  input  logic [ooksfd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ooksfd_pkg::TIME_W-1:0]      cfg_data_i
);
  import ooksfd_pkg::*;

  // configuration
  logic [TIME_W-1:0] short_time_q, long_time_q, tolerance_q;

  // input register
  logic              in_valid_q;
  logic              start_q, last_q;
  logic [TIME_W-1:0] high_q, low_q;

  // capture state
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  done_q, done_d;

  // output register
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [WORD_W-1:0] word_q, word_d;

  logic                  advance;
  logic                  emit;
  cls_t                  cls;
  chk_t                  chk;
  logic [FRAME_BITS-1:0] frame_base, frame_shift;
  logic [CNT_W-1:0]      count_base, count_inc;
  logic                  done_base;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_time_q <= SHORT_TIME_RST;
      long_time_q  <= LONG_TIME_RST;
      tolerance_q  <= TOLERANCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHORT_TIME: short_time_q <= cfg_data_i;
        CFG_LONG_TIME:  long_time_q  <= cfg_data_i;
        CFG_TOLERANCE:  tolerance_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      start_q <= start_req_i;
      last_q  <= last_pair_i;
      high_q  <= high_time_i;
      low_q   <= low_time_i;
    end
  end

  ooksfd_classify u_classify (
    .short_time_i (short_time_q),
    .long_time_i  (long_time_q),
    .tolerance_i  (tolerance_q),
    .high_time_i  (high_q),
    .low_time_i   (low_q),
    .cls_o        (cls)
  );

  assign frame_shift = {frame_base[FRAME_BITS-2:0], cls.bit_val};

  ooksfd_check u_check (
    .frame_i (frame_shift),
    .chk_o   (chk)
  );

  always_comb begin
    frame_base = start_q ? '0 : frame_q;
    count_base = start_q ? '0 : count_q;
    done_base  = start_q ? 1'b0 : done_q;
    count_inc  = (count_base < CNT_W'(FRAME_BITS)) ? count_base + 1'b1 : count_base;

    frame_d  = frame_base;
    count_d  = count_base;
    done_d   = done_base;
    emit     = 1'b0;
    status_d = ST_OK;
    word_d   = '0;

    if (!done_base) begin
      if (cls.abort) begin
        emit     = 1'b1;
        status_d = ST_TIMING;
      end else begin
        frame_d = frame_shift;
        count_d = count_inc;
        if (count_inc >= CNT_W'(FRAME_BITS)) begin
          emit     = 1'b1;
          status_d = chk.status;
          word_d   = chk.word;
        end else if (last_q) begin
          emit     = 1'b1;
          status_d = ST_SHORT;
        end
      end
    end
    if (emit) begin
      done_d = 1'b1;
    end
    out_valid_d = in_valid_q && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      count_q     <= '0;
      done_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= out_valid_d;
      if (in_valid_q) begin
        frame_q <= frame_d;
        count_q <= count_d;
        done_q  <= done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && out_valid_d) begin
      status_q <= status_d;
      word_q   <= word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_word_o = word_q;
  assign sensor_id_o = word_q[ID_LSB +: ID_W];

endmodule

// ===== hw/rtl/ooksfd_checker.sv =====
// Port-level assertions for the OOK sensor frame decoder, bound to the top.
module ooksfd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [2:0]                    status_o,
  input logic [ooksfd_pkg::WORD_W-1:0] data_word_o,
  input logic [ooksfd_pkg::ID_W-1:0]   sensor_id_o
);
  import ooksfd_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(data_word_o))
    else $error("stalled result changed");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_TIMING ||
                     status_o == ST_SHORT || status_o == ST_INV_ERR ||
                     status_o == ST_CSUM))
    else $error("illegal status code");

  a_id_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sensor_id_o == data_word_o[ID_LSB +: ID_W])
    else $error("sensor id does not match data word");

  a_no_data_on_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_TIMING || status_o == ST_SHORT)
      |-> data_word_o == '0)
    else $error("data reported on aborted capture");

endmodule

bind ook_sensor_frame_decoder ooksfd_checker u_ooksfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .data_word_o (data_word_o),
  .sensor_id_o (sensor_id_o)
);
